/* hw/rtl/fvt_pkg.sv */
// Shared types and constants for the frustum visibility test.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package fvt_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int NORMAL_W    = 16;   // Q1.14 normal components
  localparam int OFFSET_W    = 16;   // Q8.8 plane offset
  localparam int FRAC_SHIFT  = 14;   // aligns Q8.8 terms with n*p in Q.22
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Test kinds carried on the command field
  localparam logic [1:0] CMD_POINT    = 2'd0;
  localparam logic [1:0] CMD_SPHERE   = 2'd1;
  localparam logic [1:0] CMD_BOX      = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;

  // One plane register: offset in 63:48, nz 47:32, ny 31:16, nx 15:0
  typedef struct packed {
    logic signed [OFFSET_W-1:0] d;
    logic signed [NORMAL_W-1:0] nz;
    logic signed [NORMAL_W-1:0] ny;
    logic signed [NORMAL_W-1:0] nx;
  } plane_t;

  // Load enables for the three per-plane datapath stages
  typedef struct packed {
    logic sel;
    logic mul;
    logic sum;
  } stage_en_t;

endpackage

/* hw/rtl/fvt_plane_regs.sv */
// Plane register file: six 64-bit plane registers written over the cfg port.
// Depends on fvt_pkg.
`timescale 1ns / 1ps

module fvt_plane_regs
  import fvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output plane_t                planes [PLANE_COUNT]
);

  // Indexes past the last plane are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PLANE_COUNT; k++) begin
        planes[k] <= '0;
      end
    end else if (cfg_valid && (cfg_index <= REG_PLANE_FAR)) begin
      planes[cfg_index] <= plane_t'(cfg_data);
    end
  end

endmodule

/* hw/rtl/fvt_plane_unit.sv */
// Distance datapath for one plane: corner select, multiply, sum and sign.
// Depends on fvt_pkg; control comes from the top level as stage_en_t.
`timescale 1ns / 1ps

module fvt_plane_unit
  import fvt_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  stage_en_t                     en,
  input  plane_t                        plane,
  input  logic [1:0]                    command,
  input  logic signed [COORD_BITS-1:0]  pos_x,
  input  logic signed [COORD_BITS-1:0]  pos_y,
  input  logic signed [COORD_BITS-1:0]  pos_z,
  input  logic signed [COORD_BITS-1:0]  max_x,
  input  logic signed [COORD_BITS-1:0]  max_y,
  input  logic signed [COORD_BITS-1:0]  max_z,
  input  logic [COORD_BITS-2:0]         radius,
  output logic                          neg
);

  localparam int OFF_W = ((COORD_BITS > OFFSET_W) ? COORD_BITS : OFFSET_W) + 1;
  localparam int PROD_W = NORMAL_W + COORD_BITS;
  localparam int TERM_W = (PROD_W > OFF_W + FRAC_SHIFT) ? PROD_W : OFF_W + FRAC_SHIFT;
  localparam int ACC_W = TERM_W + 2;

  logic                         is_box;
  logic                         is_sphere;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] cz;
  logic signed [OFF_W-1:0]      off_b;
  logic signed [PROD_W-1:0]     px;
  logic signed [PROD_W-1:0]     py;
  logic signed [PROD_W-1:0]     pz;
  logic signed [OFF_W-1:0]      off_c;
  logic signed [ACC_W-1:0]      plane_dist;

  assign is_box    = (command == CMD_BOX);
  assign is_sphere = (command == CMD_SPHERE);

  // Positive vertex: max corner where the normal component is >= 0
  always_ff @(posedge clk) begin
    if (en.sel) begin
      cx <= (is_box && !plane.nx[NORMAL_W-1]) ? max_x : pos_x;
      cy <= (is_box && !plane.ny[NORMAL_W-1]) ? max_y : pos_y;
      cz <= (is_box && !plane.nz[NORMAL_W-1]) ? max_z : pos_z;
      off_b <= is_sphere
               ? OFF_W'(plane.d) + signed'(OFF_W'(radius))
               : OFF_W'(plane.d);
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      px    <= PROD_W'(plane.nx) * PROD_W'(cx);
      py    <= PROD_W'(plane.ny) * PROD_W'(cy);
      pz    <= PROD_W'(plane.nz) * PROD_W'(cz);
      off_c <= off_b;
    end
  end

  assign plane_dist = ACC_W'(px) + ACC_W'(py) + ACC_W'(pz) + (ACC_W'(off_c) <<< FRAC_SHIFT);

  always_ff @(posedge clk) begin
    if (en.sum) begin
      neg <= plane_dist[ACC_W-1];
    end
  end

endmodule

/* hw/rtl/frustum_visibility_test.sv */
// Frustum visibility test, top level. Uses fvt_pkg, fvt_plane_regs, fvt_plane_unit.
// An accepted item passes the corner-select, multiply and sum/sign stage registers into the output register.
// Throughput: one item per cycle while the output does not stall; the six plane datapaths run side by side.
// Backpressure ripples back through the stage valids; a stall holds each full
// stage while empty stages behind it keep filling.
// Reset (rst, synchronous): clears stage valids and zeroes all plane registers,
// so every test but the reserved command passes until planes are written.
`timescale 1ns / 1ps

module frustum_visibility_test
  import fvt_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  // item channel
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [1:0]                    command,
  input  logic signed [COORD_BITS-1:0]  pos_x,
  input  logic signed [COORD_BITS-1:0]  pos_y,
  input  logic signed [COORD_BITS-1:0]  pos_z,
  input  logic signed [COORD_BITS-1:0]  max_x,
  input  logic signed [COORD_BITS-1:0]  max_y,
  input  logic signed [COORD_BITS-1:0]  max_z,
  input  logic [COORD_BITS-2:0]         radius,
  // result channel
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          visible
);

  plane_t                 planes [PLANE_COUNT];
  stage_en_t              en;
  logic [PLANE_COUNT-1:0] neg;

  // Stage valids: b = corner select, c = multiply, d = sum/sign, result = output
  logic vld_b, vld_c, vld_d;
  logic rdy_b, rdy_c, rdy_d, rdy_out;
  // The reserved command rides alongside the datapath and forces a fail
  logic cmd_ok_b, cmd_ok_c, cmd_ok_d;

  // Registers are always writable; the user must change planes only while the block is idle (not enforced here)
  assign cfg_ready = 1'b1;

  fvt_plane_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  // A stage can load when it is empty or its content moves on this cycle
  assign rdy_out    = !result_valid || result_ready;
  assign rdy_d      = !vld_d || rdy_out;
  assign rdy_c      = !vld_c || rdy_d;
  assign rdy_b      = !vld_b || rdy_c;
  assign item_ready = rdy_b;

  assign en.sel = rdy_b;
  assign en.mul = rdy_c;
  assign en.sum = rdy_d;

  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_plane
    fvt_plane_unit #(
      .COORD_BITS (COORD_BITS)
    ) u_unit (
      .clk     (clk),
      .en      (en),
      .plane   (planes[k]),
      .command (command),
      .pos_x   (pos_x),
      .pos_y   (pos_y),
      .pos_z   (pos_z),
      .max_x   (max_x),
      .max_y   (max_y),
      .max_z   (max_z),
      .radius  (radius),
      .neg     (neg[k])
    );
  end

  // Control valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b        <= 1'b0;
      vld_c        <= 1'b0;
      vld_d        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy_b) begin
        vld_b <= item_valid;
      end
      if (rdy_c) begin
        vld_c <= vld_b;
      end
      if (rdy_d) begin
        vld_d <= vld_c;
      end
      if (rdy_out) begin
        result_valid <= vld_d;
      end
    end
  end

  // Side-band payload and the final AND over all planes
  always_ff @(posedge clk) begin
    if (rdy_b) begin
      cmd_ok_b <= (command != CMD_RESERVED);
    end
    if (rdy_c) begin
      cmd_ok_c <= cmd_ok_b;
    end
    if (rdy_d) begin
      cmd_ok_d <= cmd_ok_c;
    end
    if (rdy_out) begin
      visible <= cmd_ok_d && !(|neg);
    end
  end

endmodule

/* hw/rtl/fvt_checker.sv */
// Port-level checks for frustum_visibility_test, bound to the top level.
// Depends on fvt_pkg.
`timescale 1ns / 1ps

module fvt_checker
  import fvt_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic [1:0]                    command,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic                          visible
);

  // A pending result holds until its transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(visible))
    else $error("result dropped or changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // With the output register empty nothing upstream can be blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with empty output");

  // A result follows each item transfer while the consumer keeps taking results
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) ##1 result_ready ##1 result_ready ##1 result_ready
    |=> result_valid)
    else $error("result missing after pipeline latency");

  // The reserved command never reports visible
  a_reserved_fails: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && command == CMD_RESERVED)
    ##1 result_ready ##1 result_ready ##1 result_ready
    |=> result_valid && !visible)
    else $error("reserved command reported visible");

endmodule

bind frustum_visibility_test fvt_checker u_fvt_checker (.*);

/* tb/sv/fvt_scoreboard_pkg.sv */
// Scoreboard for the frustum visibility test bench: item type, plane store
// and the visibility predictor. Depends on fvt_pkg for plane and command codes.
`timescale 1ns / 1ps

package fvt_scoreboard_pkg;
  import fvt_pkg::*;

  localparam int COORD_W = 16;
  localparam longint OFFSET_SCALE = 64'sd1 <<< FRAC_SHIFT;

  // Indexes past the plane map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
    logic [COORD_W-2:0]        radius;
  } cull_item_t;

  class visibility_scoreboard;
    plane_t      planes[PLANE_COUNT];
    bit          expected_visible[$];
    int unsigned mismatches;

    function new();
      foreach (planes[k]) planes[k] = '0;
      mismatches = 0;
    endfunction

    function void write_plane(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < PLANE_COUNT) planes[idx] = plane_t'(data);
    endfunction

    // Exact six-plane test; Q.22 distances in 64 bits never overflow
    function bit predict_visible(cull_item_t it);
      longint plane_dist;
      longint cx;
      longint cy;
      longint cz;
      bit     pass;
      pass = (it.command != CMD_RESERVED);
      for (int k = 0; k < PLANE_COUNT; k++) begin
        if (it.command == CMD_BOX) begin
          // positive vertex: zero normal component picks the max corner
          cx = (planes[k].nx >= 0) ? longint'(it.max_x) : longint'(it.pos_x);
          cy = (planes[k].ny >= 0) ? longint'(it.max_y) : longint'(it.pos_y);
          cz = (planes[k].nz >= 0) ? longint'(it.max_z) : longint'(it.pos_z);
        end else begin
          cx = longint'(it.pos_x);
          cy = longint'(it.pos_y);
          cz = longint'(it.pos_z);
        end
        plane_dist = longint'(planes[k].nx) * cx + longint'(planes[k].ny) * cy
                   + longint'(planes[k].nz) * cz + longint'(planes[k].d) * OFFSET_SCALE;
        if (it.command == CMD_SPHERE) plane_dist += longint'(it.radius) * OFFSET_SCALE;
        if (plane_dist < 0) pass = 1'b0;
      end
      return pass;
    endfunction

    function void note_item(cull_item_t it);
      expected_visible.push_back(predict_visible(it));
    endfunction

    function void check_result(logic vis);
      bit exp_vis;
      if (expected_visible.size() == 0) begin
        $error("visible: no result expected, actual %0b", vis);
        mismatches++;
      end else begin
        exp_vis = expected_visible.pop_front();
        if (vis !== exp_vis) begin
          $error("visible: expected %0b, actual %0b", exp_vis, vis);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_visible.size();
    endfunction
  endclass

endpackage

/* tb/sv/testbench.sv */
// Top of the frustum visibility test bench: clock, reset, stimulus, checking.
// Depends on fvt_pkg, fvt_scoreboard_pkg and the frustum_visibility_test RTL.
`timescale 1ns / 1ps

module testbench;
  import fvt_pkg::*;
  import fvt_scoreboard_pkg::*;

  localparam int ITEMS_PER_PHASE = 250;
  localparam int PHASE_COUNT     = 8;
  localparam int DRAIN_CYCLES    = 8;     // pipeline is 4 deep, keep some margin
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT     = 4000;  // cycles with no transfer at all

  // Plane sets used across the run
  typedef enum int {
    SET_CUBE, SET_AXIS, SET_TILTED, SET_RANDOM, SET_MIXED,
    SET_EXTREME, SET_MAX_EXTREME, SET_MIN_EXTREME, SET_ZERO
  } plane_set_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data  = '0;
  logic                         item_valid = 1'b0;
  logic                         item_ready;
  logic [1:0]                   command = CMD_POINT;
  logic signed [COORD_W-1:0]    pos_x = '0;
  logic signed [COORD_W-1:0]    pos_y = '0;
  logic signed [COORD_W-1:0]    pos_z = '0;
  logic signed [COORD_W-1:0]    max_x = '0;
  logic signed [COORD_W-1:0]    max_y = '0;
  logic signed [COORD_W-1:0]    max_z = '0;
  logic [COORD_W-2:0]           radius = '0;
  logic                         result_valid;
  logic                         result_ready = 1'b0;
  logic                         visible;

  // Idle/stall odds in percent, changed per phase by the main sequence
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  bit          hold_req     = 1'b0;
  int          hold_left    = 0;
  int unsigned quiet_cycles = 0;

  visibility_scoreboard sb = new();

  frustum_visibility_test #(
    .COORD_BITS(COORD_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .max_x        (max_x),
    .max_y        (max_y),
    .max_z        (max_z),
    .radius       (radius),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .visible      (visible)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sampling happens at the falling edge: all inputs change only at the rising
  // edge, so the values seen here are exactly the ones the next rising edge
  // samples. A result transfer seen here completes at that next edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(visible);
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here when asked
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------

  // One register transfer; cfg_valid is left high for a back-to-back write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    sb.write_plane(idx, data);
  endtask

  function automatic logic [15:0] extreme_word();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Plane k of a set; k even faces +axis, k odd faces -axis (left/right etc.)
  function automatic plane_t plane_for(plane_set_e set, int k);
    plane_t p;
    int     comp[3];
    int     sgn;
    int     off;
    sgn = (k % 2 == 0) ? 1 : -1;
    comp[0] = 0;
    comp[1] = 0;
    comp[2] = 0;
    off = 0;
    case (set)
      SET_CUBE: begin
        comp[k / 2] = sgn * 16384;
        off = 16'sh0400;                // half extent 4.0
      end
      SET_AXIS: begin
        comp[k / 2] = sgn * 16384;
        off = $urandom_range(8192, 256);
      end
      SET_TILTED: begin
        foreach (comp[a]) comp[a] = int'($urandom_range(12000)) - 6000;
        comp[k / 2] = sgn * int'($urandom_range(16384, 12000));
        off = int'($urandom_range(12000)) - 512;
      end
      SET_RANDOM:  return plane_t'({$urandom, $urandom});
      SET_MIXED:   return ($urandom_range(1) == 0) ? plane_t'({$urandom, $urandom})
                                                   : plane_for(SET_TILTED, k);
      SET_EXTREME: return plane_t'({extreme_word(), extreme_word(),
                                    extreme_word(), extreme_word()});
      SET_MAX_EXTREME: return plane_t'({4{16'h7FFF}});
      SET_MIN_EXTREME: return plane_t'({4{16'h8000}});
      default:     return '0;
    endcase
    p.nx = comp[0][15:0];
    p.ny = comp[1][15:0];
    p.nz = comp[2][15:0];
    p.d  = off[15:0];
    return p;
  endfunction

  // All six planes, then writes to unmapped indexes that must be ignored
  task automatic load_planes(plane_set_e set);
    write_reg(REG_PLANE_LEFT,   plane_for(set, 0));
    write_reg(REG_PLANE_RIGHT,  plane_for(set, 1));
    write_reg(REG_PLANE_BOTTOM, plane_for(set, 2));
    write_reg(REG_PLANE_TOP,    plane_for(set, 3));
    write_reg(REG_PLANE_NEAR,   plane_for(set, 4));
    write_reg(REG_PLANE_FAR,    plane_for(set, 5));
    write_reg(REG_UNUSED_LO, {$urandom, $urandom});
    write_reg(REG_UNUSED_HI, {64{1'b1}});
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Items
  // ---------------------------------------------------------------------------

  function automatic cull_item_t make_item(logic [1:0] cmd, int px, int py, int pz,
                                           int qx, int qy, int qz, int r);
    cull_item_t it;
    it.command = cmd;
    it.pos_x = px[COORD_W-1:0];
    it.pos_y = py[COORD_W-1:0];
    it.pos_z = pz[COORD_W-1:0];
    it.max_x = qx[COORD_W-1:0];
    it.max_y = qy[COORD_W-1:0];
    it.max_z = qz[COORD_W-1:0];
    it.radius = r[COORD_W-2:0];
    return it;
  endfunction

  // Mostly near the planes of the generated sets, sometimes anywhere
  function automatic int rand_coord();
    if ($urandom_range(9) < 8) return int'($urandom_range(24000)) - 12000;
    return int'($signed($urandom_range(16'hFFFF) - 32768));
  endfunction

  // Box upper bound: usually above lo, saturated at the top of the range
  function automatic int box_hi(int lo);
    int hi;
    if ($urandom_range(9) == 0) return rand_coord();   // inverted or arbitrary
    hi = lo + int'($urandom_range(6000));
    return (hi > 32767) ? 32767 : hi;
  endfunction

  function automatic cull_item_t random_item();
    logic [1:0] cmd;
    int         px;
    int         py;
    int         pz;
    int         r;
    int         pick;
    pick = $urandom_range(99);
    cmd = (pick < 30) ? CMD_POINT : (pick < 60) ? CMD_SPHERE :
          (pick < 95) ? CMD_BOX : CMD_RESERVED;
    px = rand_coord();
    py = rand_coord();
    pz = rand_coord();
    r  = ($urandom_range(9) < 8) ? $urandom_range(4096) : $urandom_range(32767);
    // unused fields carry random data as well; the block must ignore them
    return make_item(cmd, px, py, pz, box_hi(px), box_hi(py), box_hi(pz), r);
  endfunction

  // One item transfer; idle gaps come first so valid never drops mid-offer
  task automatic send_item(cull_item_t it);
    bit took;
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    command    <= it.command;
    pos_x      <= it.pos_x;
    pos_y      <= it.pos_y;
    pos_z      <= it.pos_z;
    max_x      <= it.max_x;
    max_y      <= it.max_y;
    max_z      <= it.max_z;
    radius     <= it.radius;
    do begin
      @(negedge clk);
      took = item_ready;
      @(posedge clk);
    end while (!took);
    sb.note_item(it);
  endtask

  // Block goes idle: all results in, then a drain wait for the pipeline
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  plane_set_e phase_set[PHASE_COUNT] = '{SET_AXIS, SET_TILTED, SET_RANDOM, SET_MIXED,
                                         SET_EXTREME, SET_ZERO, SET_TILTED, SET_AXIS};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset planes are all zero: everything passes but the reserved command
    send_item(make_item(CMD_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
    send_item(make_item(CMD_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
    send_item(make_item(CMD_SPHERE, -32768, 32767, 0, 0, 0, 0, 32767));
    send_item(make_item(CMD_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 0));
    send_item(make_item(CMD_RESERVED, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Cube of half extent 4.0 (raw 0x400): inside, touching, just outside
    load_planes(SET_CUBE);
    send_item(make_item(CMD_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_POINT, -1024, 0, 0, 0, 0, 0, 0));       // on left plane
    send_item(make_item(CMD_POINT, -1025, 0, 0, 0, 0, 0, 0));       // just outside
    send_item(make_item(CMD_POINT, 0, 0, 1024, 0, 0, 0, 0));        // on far plane
    send_item(make_item(CMD_SPHERE, -2048, 0, 0, 0, 0, 0, 1024));   // touches
    send_item(make_item(CMD_SPHERE, -2048, 0, 0, 0, 0, 0, 1023));   // misses by 1
    send_item(make_item(CMD_SPHERE, -32768, 0, 0, 0, 0, 0, 32767)); // big radius
    send_item(make_item(CMD_BOX, -4096, -4096, -4096, -1024, -1024, -1024, 0));
    send_item(make_item(CMD_BOX, 1280, 0, 0, 1536, 256, 256, 0));   // fully right
    send_item(make_item(CMD_BOX, 768, 768, 768, -768, -768, -768, 0)); // inverted
    send_item(make_item(CMD_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    send_item(make_item(CMD_RESERVED, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_POINT, 32767, -32768, 32767, -1, -1, -1, 32767));
    drain();

    // Extreme plane words: largest products, both signs
    load_planes(SET_MAX_EXTREME);
    send_item(make_item(CMD_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
    send_item(make_item(CMD_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    drain();
    load_planes(SET_MIN_EXTREME);
    send_item(make_item(CMD_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767));
    send_item(make_item(CMD_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    drain();

    // Random phases, idling pattern rotates: none, sender, receiver, both
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      load_planes(phase_set[ph]);
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 71; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 71; end
        default: begin tx_idle_pct = 28; rx_stall_pct = 28; end
      endcase
      if (ph == 0) begin
        // long receiver hold-off while the sender keeps offering: fills the
        // pipeline and must back-pressure the item channel
        @(negedge clk);
        hold_req = 1'b1;
        @(posedge clk);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_item());
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
